>>> hw/rtl/epc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epc_pkg
// Shared types and constants of the eye pixel compositor.
// ----------------------------------------------------------------------------
package epc_pkg;

    // texture depth, a power of two; lookups and writes wrap on it
    localparam int TEXTURE_WORDS = 65536;
    localparam int TEX_AW        = $clog2(TEXTURE_WORDS);
    localparam int MAX_MAP_WIDTH = 512;

    localparam int PIX_W     = 16;
    localparam int LID_W     = 8;
    localparam int POLAR_W   = 16;
    localparam int RADIUS_W  = 7;               // radius field, mask 0x7F
    localparam int ANGLE_W   = POLAR_W - RADIUS_W;
    localparam int SCALE_SH  = $clog2(128);     // iris scale in units of 1/128
    localparam int ANGLE_SH  = $clog2(512);     // angle range of the polar word
    localparam int SCALE_W   = 10;
    localparam int MAPW_W    = 10;
    localparam int MAPH_W    = 8;
    localparam int DIST_W    = SCALE_W + RADIUS_W - SCALE_SH;
    localparam int COL_W     = MAPW_W + ANGLE_W - ANGLE_SH;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DW    = 10;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_RENDER = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_UPPER_THR  = 3'd0,
        REG_LOWER_THR  = 3'd1,
        REG_IRIS_SCALE = 3'd2,
        REG_MAP_WIDTH  = 3'd3,
        REG_MAP_HEIGHT = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        SRC_BLACK  = 2'd0,
        SRC_SCLERA = 2'd1,
        SRC_IRIS   = 2'd2
    } t_src;

    typedef struct packed {
        logic [LID_W-1:0]  upper_thr;
        logic [LID_W-1:0]  lower_thr;
        logic [SCALE_W-1:0] iris_scale;
        logic [MAPW_W-1:0] map_width;   // already saturated
        logic [MAPH_W-1:0] map_height;
    } t_cfg;

    typedef struct packed {
        logic               valid;
        logic               req_type;
        logic [15:0]        texel_addr;
        logic [PIX_W-1:0]   texel_data;
        logic [LID_W-1:0]   lower_lid;
        logic [LID_W-1:0]   upper_lid;
        logic [PIX_W-1:0]   sclera_pixel;
        logic [POLAR_W-1:0] polar_word;
        logic               iris_in_range;
    } t_req;

    typedef struct packed {
        logic              valid;
        logic              is_wr;
        logic [TEX_AW-1:0] wr_addr;
        logic [PIX_W-1:0]  wr_data;
        logic [PIX_W-1:0]  sclera;
        t_src              src;
        logic [DIST_W-1:0] rad_sc;
        logic [COL_W-1:0]  col;
    } t_s1;

    typedef struct packed {
        logic              valid;
        logic              is_wr;
        logic [TEX_AW-1:0] wr_addr;
        logic [PIX_W-1:0]  wr_data;
        logic [PIX_W-1:0]  sclera;
        t_src              src;
        logic [TEX_AW-1:0] tex_addr;
    } t_s2;

    typedef struct packed {
        logic             valid;
        t_src             src;
        logic [PIX_W-1:0] sclera;
        logic [PIX_W-1:0] texel;
    } t_s3;

endpackage

>>> hw/rtl/epc_intf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epc_intf
// Valid/ready channels of the compositor: render and texture words in,
// pixels out, register writes.
// ----------------------------------------------------------------------------
interface epc_in_if;
    import epc_pkg::*;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [15:0]        texel_addr;
    logic [PIX_W-1:0]   texel_data;
    logic [LID_W-1:0]   lower_lid;
    logic [LID_W-1:0]   upper_lid;
    logic [PIX_W-1:0]   sclera_pixel;
    logic [POLAR_W-1:0] polar_word;
    logic               iris_in_range;

    modport source (output valid, req_type, texel_addr, texel_data, lower_lid,
                    upper_lid, sclera_pixel, polar_word, iris_in_range,
                    input ready);
    modport sink (input valid, req_type, texel_addr, texel_data, lower_lid,
                  upper_lid, sclera_pixel, polar_word, iris_in_range,
                  output ready);
endinterface

interface epc_out_if;
    import epc_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic [1:0]       pixel_source;

    modport source (output valid, pixel, pixel_source, input ready);
    modport sink (input valid, pixel, pixel_source, output ready);
endinterface

interface epc_cfg_if;
    import epc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DW-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/epc_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epc_regs
// Configuration registers: lid thresholds, iris scale and map size.
// ----------------------------------------------------------------------------
module epc_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    epc_cfg_if.sink        i_cfg,
    output epc_pkg::t_cfg  o_cfg
);
    import epc_pkg::*;

    logic [LID_W-1:0]   r_upper_thr;
    logic [LID_W-1:0]   r_lower_thr;
    logic [SCALE_W-1:0] r_iris_scale;
    logic [MAPW_W-1:0]  r_map_width;
    logic [MAPH_W-1:0]  r_map_height;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper_thr  <= '0;
            r_lower_thr  <= '0;
            r_iris_scale <= SCALE_W'(512);
            r_map_width  <= MAPW_W'(256);
            r_map_height <= MAPH_W'(64);
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_UPPER_THR:  r_upper_thr  <= i_cfg.data[LID_W-1:0];
                REG_LOWER_THR:  r_lower_thr  <= i_cfg.data[LID_W-1:0];
                REG_IRIS_SCALE: r_iris_scale <= i_cfg.data[SCALE_W-1:0];
                REG_MAP_WIDTH:  r_map_width  <= i_cfg.data[MAPW_W-1:0];
                REG_MAP_HEIGHT: r_map_height <= i_cfg.data[MAPH_W-1:0];
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    always_comb begin
        o_cfg.upper_thr  = r_upper_thr;
        o_cfg.lower_thr  = r_lower_thr;
        o_cfg.iris_scale = r_iris_scale;
        o_cfg.map_width  = (32'(r_map_width) > MAX_MAP_WIDTH)
                         ? MAPW_W'(MAX_MAP_WIDTH) : r_map_width;
        o_cfg.map_height = r_map_height;
    end

endmodule

>>> hw/rtl/epc_polar.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epc_polar
// Stages one and two: lid masking, radius and angle scaling, then the
// radial range check and texture address.
// ----------------------------------------------------------------------------
module epc_polar (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  epc_pkg::t_cfg i_cfg,
    input  epc_pkg::t_req i_req,
    output epc_pkg::t_s2  o_s2
);
    import epc_pkg::*;

    localparam int PD_W  = SCALE_W + RADIUS_W;
    localparam int PA_W  = MAPW_W + ANGLE_W;
    localparam int SUM_W = 32;

    t_s1 r_s1, n_s1;
    t_s2 r_s2, n_s2;

    logic [PD_W-1:0]  prod_d;
    logic [PA_W-1:0]  prod_a;
    logic             black;
    logic [SUM_W-1:0] tex_sum;

    // stage one
    always_comb begin
        prod_d = PD_W'(i_cfg.iris_scale) * PD_W'(i_req.polar_word[RADIUS_W-1:0]);
        prod_a = PA_W'(i_cfg.map_width) * PA_W'(i_req.polar_word[POLAR_W-1:RADIUS_W]);
        black  = (i_req.lower_lid <= i_cfg.lower_thr)
              || (i_req.upper_lid <= i_cfg.upper_thr);

        n_s1.valid   = i_req.valid;
        n_s1.is_wr   = (i_req.req_type == REQ_WRITE);
        n_s1.wr_addr = TEX_AW'(i_req.texel_addr);
        n_s1.wr_data = i_req.texel_data;
        n_s1.sclera  = i_req.sclera_pixel;
        n_s1.src     = black ? SRC_BLACK : (i_req.iris_in_range ? SRC_IRIS : SRC_SCLERA);
        n_s1.rad_sc  = prod_d[PD_W-1:SCALE_SH];
        n_s1.col     = prod_a[PA_W-1:ANGLE_SH];
    end

    // stage two
    always_comb begin
        tex_sum = SUM_W'(r_s1.rad_sc) * SUM_W'(i_cfg.map_width) + SUM_W'(r_s1.col);

        n_s2.valid    = r_s1.valid;
        n_s2.is_wr    = r_s1.is_wr;
        n_s2.wr_addr  = r_s1.wr_addr;
        n_s2.wr_data  = r_s1.wr_data;
        n_s2.sclera   = r_s1.sclera;
        n_s2.tex_addr = tex_sum[TEX_AW-1:0];
        // fall back to sclera beyond the map's radial extent
        if (r_s1.src == SRC_IRIS && r_s1.rad_sc >= DIST_W'(i_cfg.map_height)) begin
            n_s2.src = SRC_SCLERA;
        end else begin
            n_s2.src = r_s1.src;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
        end else if (i_adv) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule

>>> hw/rtl/epc_tex_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epc_tex_ram
// Stage three: iris texture memory. Write words store here and end; render
// words with an iris source read their texel into the output register.
// ----------------------------------------------------------------------------
module epc_tex_ram (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_adv,
    input  epc_pkg::t_s2 i_s2,
    output epc_pkg::t_s3 o_s3
);
    import epc_pkg::*;

    logic [PIX_W-1:0] mem [TEXTURE_WORDS];
    logic [PIX_W-1:0] r_texel;
    logic             r_valid;
    t_src             r_src;
    logic [PIX_W-1:0] r_sclera;

    always_ff @(posedge i_clk) begin
        if (i_adv && i_s2.valid && i_s2.is_wr) begin
            mem[i_s2.wr_addr] <= i_s2.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_s2.valid && !i_s2.is_wr && i_s2.src == SRC_IRIS) begin
            r_texel <= mem[i_s2.tex_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_s2.valid && !i_s2.is_wr;  // write words leave no pixel
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_src    <= i_s2.src;
            r_sclera <= i_s2.sclera;
        end
    end

    always_comb begin
        o_s3.valid  = r_valid;
        o_s3.src    = r_src;
        o_s3.sclera = r_sclera;
        o_s3.texel  = r_texel;
    end

endmodule

>>> hw/rtl/eye_pixel_compositor.sv
`timescale 1ns / 1ps
// Pipeline: three register stages, stage one, stage two and the stage-three
// output register; a pixel word passes through them in that order.
// Throughput: one word per cycle; the three stages freeze together on a stall.
// The texture memory has one write and one registered read port at stage three.
// Reset clears the stage valid bits and loads register defaults; the texture
// memory keeps its contents and holds garbage until written.
// ----------------------------------------------------------------------------
// eye_pixel_compositor
// Eyelid masking, sclera pass-through and polar iris texture lookup.
// ----------------------------------------------------------------------------
module eye_pixel_compositor (
    input  logic      i_clk,
    input  logic      i_rst_n,
    epc_in_if.sink    i_pix_in,
    epc_out_if.source o_pix_out,
    epc_cfg_if.sink   i_cfg
);
    import epc_pkg::*;

    t_cfg cfg;
    t_req req;
    t_s2  s2;
    t_s3  s3;
    logic adv;

    // advance whenever the output register is empty or being taken
    assign adv = !s3.valid || o_pix_out.ready;
    assign i_pix_in.ready = adv;

    always_comb begin
        req.valid         = i_pix_in.valid;
        req.req_type      = i_pix_in.req_type;
        req.texel_addr    = i_pix_in.texel_addr;
        req.texel_data    = i_pix_in.texel_data;
        req.lower_lid     = i_pix_in.lower_lid;
        req.upper_lid     = i_pix_in.upper_lid;
        req.sclera_pixel  = i_pix_in.sclera_pixel;
        req.polar_word    = i_pix_in.polar_word;
        req.iris_in_range = i_pix_in.iris_in_range;
    end

    epc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    epc_polar u_polar (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_cfg   (cfg),
        .i_req   (req),
        .o_s2    (s2)
    );

    epc_tex_ram u_tex (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_s2    (s2),
        .o_s3    (s3)
    );

    assign o_pix_out.valid        = s3.valid;
    assign o_pix_out.pixel_source = s3.src;
    always_comb begin
        case (s3.src)
            SRC_IRIS:   o_pix_out.pixel = s3.texel;
            SRC_SCLERA: o_pix_out.pixel = s3.sclera;
            default:    o_pix_out.pixel = '0;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_black_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix_out.valid && o_pix_out.pixel_source == SRC_BLACK |-> o_pix_out.pixel == '0)
        else $error("black pixel carries colour");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix_out.valid && !o_pix_out.ready |-> !i_pix_in.ready)
        else $error("input taken while output stalled");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_pix_out.valid)
        else $error("pixel offered straight after reset");

    a_stall_holds_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix_out.valid && !o_pix_out.ready |=> $stable(o_pix_out.pixel_source))
        else $error("pixel source changed under stall");
`endif

endmodule
